// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl
// no dependencies; bodies compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== sv/sed_pkg.sv =====
// types and constants of the sparse euclidean distance unit
// used by the front, back and top level
package sed_pkg;

	localparam int IN_KEY_W = 32;
	localparam int SCORE_W  = 16;
	localparam int DIST_W   = 21;
	localparam logic [19:0] DIST_MAX = 20'hFFFFF;

	typedef enum logic [1:0] {
		KIND_APPEND_A = 2'd0,
		KIND_APPEND_B = 2'd1,
		KIND_COMPUTE  = 2'd2,
		KIND_SHARE    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                      kind;
		logic [IN_KEY_W-1:0]        key;
		logic signed [SCORE_W-1:0]  score;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_COMPARE,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_ROOT_GO,
		ST_ROOT_WAIT
	} back_state_t;

endpackage

// ===== sv/sparse_euclidean_distance_unit.sv =====
// top level of the sparse euclidean distance unit
// depends on sed_pkg, sed_front, sed_back and assert_macros.svh
//
// usage: one input stream, one result stream. each input beat carries an
// operation in s_axis_tuser: append to list a, append to list b, compute the
// distance, or test for a shared key. every input beat gives exactly one
// result beat, in order.
// an append answers with a status (1 when the list is full and the entry
// dropped). a compute walks both lists in merge order, each merge step a
// memory read then a compare, with a final check; then the square and
// accumulate drain (ST_DRAIN1, ST_DRAIN2), then the root (one bit per cycle),
// then the result register is loaded. a share test stops at the first match
// or when either list runs out.
// both requests empty the lists.
// a two-entry command queue sits between the input side and the execution
// unit, so input beats are taken while a result waits; when the receiver
// stalls, the result register holds and the queue fills, then s_axis_tready
// drops. reset clears counts, queue and result register; no clearing pass.
`include "assert_macros.svh"
module sparse_euclidean_distance_unit import sed_pkg::*; #(
	parameter int MAX_ENTRIES = 256,
	parameter int KEY_WIDTH   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // key[31:0], score[47:32]
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // status[0], neg_distance[21:1], shared[22], zero[23]
);

	logic              cmd_valid;
	logic              cmd_ready;
	cmd_t              cmd;
	logic              status;
	logic              shared;
	logic [DIST_W-1:0] neg_distance;

	sed_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	sed_back #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.KEY_WIDTH   (KEY_WIDTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd_ready        (cmd_ready),
		.cmd              (cmd),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.out_status       (status),
		.out_neg_distance (neg_distance),
		.out_shared       (shared)
	);

	assign m_axis_tdata = {1'b0, shared, neg_distance, status};

	`ASSERT_NEVER(a_status_alone, clk, arst_n, m_axis_tvalid && status && (shared || neg_distance != '0))
	`ASSERT_NEVER(a_share_no_dist, clk, arst_n, m_axis_tvalid && shared && neg_distance != '0)
	`ASSERT_NEVER(a_dist_not_pos, clk, arst_n, m_axis_tvalid && !neg_distance[DIST_W-1] && neg_distance != '0)
	`ASSERT_ALWAYS(a_queue_drains, clk, arst_n, (!s_axis_tready && cmd_ready) |=> s_axis_tready)

endmodule

// ===== sv/sed_front.sv =====
// input side: takes beats, decodes the operation and queues commands
// depends on sed_pkg
module sed_front import sed_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_op,
	input  logic [47:0] in_data,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	cmd_t       dec;
	logic       push;
	logic       pop;

	always_comb begin
		dec.kind  = kind_t'(in_op);
		dec.key   = in_data[IN_KEY_W-1:0];
		dec.score = in_data[IN_KEY_W +: SCORE_W];
	end

	assign in_ready  = (fill_q != 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== sv/sed_isqrt.sv =====
// digit-by-digit integer square root, one result bit per cycle
// no package dependencies
module sed_isqrt #(
	parameter int RAD_W = 42
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [RAD_W-1:0]   rad,
	output logic               done,
	output logic [RAD_W/2-1:0] root
);

	localparam int H     = RAD_W / 2;
	localparam int STEP_W = $clog2(H + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [H+1:0]      rem_q;
	logic [H-1:0]      root_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [H+1:0]      rem_next;
	logic [H+1:0]      trial;
	logic              fits;

	assign rem_next = {rem_q[H-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial    = {root_q, 2'b01};
	assign fits     = (rem_next >= trial);
	assign done     = done_q;
	assign root     = root_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_next - trial) : rem_next;
			root_q <= {root_q[H-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(H);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== sv/sed_back.sv =====
// execution side: list memories, merge walk, sum of squares and result register
// depends on sed_pkg and sed_isqrt
module sed_back import sed_pkg::*; #(
	parameter int MAX_ENTRIES = 256,
	parameter int KEY_WIDTH   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  cmd_t              cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_status,
	output logic [DIST_W-1:0] out_neg_distance,
	output logic              out_shared
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int SUM_W = 32 + $clog2(2 * MAX_ENTRIES);
	localparam int H     = (SUM_W + 1) / 2;
	localparam int RAD_W = 2 * H;
	localparam int EXT_W = (H > 20) ? H : 20;
	localparam int ENT_W = KEY_WIDTH + SCORE_W;

	back_state_t state_q, state_d;

	logic [ENT_W-1:0] mem_a [MAX_ENTRIES];
	logic [ENT_W-1:0] mem_b [MAX_ENTRIES];
	logic [ENT_W-1:0] rd_a_q, rd_b_q;
	logic [CNT_W-1:0] cnt_a_q, cnt_b_q, i_q, j_q;
	kind_t            kind_q;
	logic [SUM_W-1:0] total_q;
	logic [15:0]      mag_s1;
	logic             mag_v_s1;
	logic [31:0]      prod_s2;
	logic             prod_v_s2;
	logic             out_valid_q, out_status_q, out_shared_q;
	logic [DIST_W-1:0] out_neg_q;

	logic pop, out_free, we_a, we_b, full_a, full_b;
	logic a_ok, b_ok, eq, take_a, take_b, walk_end, share_end;
	logic [KEY_WIDTH-1:0] ka, kb, new_key;
	logic signed [SCORE_W-1:0] sa, sb;
	logic signed [SCORE_W:0]   v;
	logic [SCORE_W:0]          v_abs;
	logic root_start, root_done;
	logic [H-1:0]     root;
	logic [EXT_W-1:0] root_ext;
	logic [19:0]      dist_sat;

	assign out_free  = !out_valid_q || out_ready;
	assign cmd_ready = (state_q == ST_IDLE) && out_free;
	assign pop       = cmd_valid && cmd_ready;
	assign full_a    = (cnt_a_q == CNT_W'(MAX_ENTRIES));
	assign full_b    = (cnt_b_q == CNT_W'(MAX_ENTRIES));
	assign we_a      = pop && (cmd.kind == KIND_APPEND_A) && !full_a;
	assign we_b      = pop && (cmd.kind == KIND_APPEND_B) && !full_b;
	assign new_key   = KEY_WIDTH'(cmd.key);

	assign ka = rd_a_q[ENT_W-1 -: KEY_WIDTH];
	assign kb = rd_b_q[ENT_W-1 -: KEY_WIDTH];
	assign sa = rd_a_q[SCORE_W-1:0];
	assign sb = rd_b_q[SCORE_W-1:0];

	always_comb begin
		a_ok      = (i_q < cnt_a_q);
		b_ok      = (j_q < cnt_b_q);
		eq        = a_ok && b_ok && (ka == kb);
		take_a    = !eq && a_ok && (!b_ok || (ka < kb));
		take_b    = !eq && !take_a && b_ok;
		walk_end  = !a_ok && !b_ok;
		share_end = !(a_ok && b_ok) || eq;
		if (eq) begin
			v = (SCORE_W+1)'(sa) - (SCORE_W+1)'(sb);
		end else if (take_a) begin
			v = (SCORE_W+1)'(sa);
		end else begin
			v = (SCORE_W+1)'(sb);
		end
		v_abs = v[SCORE_W] ? (SCORE_W+1)'(-v) : v;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pop && (cmd.kind == KIND_COMPUTE || cmd.kind == KIND_SHARE)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_COMPARE;
			ST_COMPARE: begin
				if (kind_q == KIND_SHARE) begin
					state_d = share_end ? ST_IDLE : ST_READ;
				end else begin
					state_d = walk_end ? ST_DRAIN1 : ST_READ;
				end
			end
			ST_DRAIN1:    state_d = ST_DRAIN2;
			ST_DRAIN2:    state_d = ST_ROOT_GO;
			ST_ROOT_GO:   state_d = ST_ROOT_WAIT;
			ST_ROOT_WAIT: state_d = root_done ? ST_IDLE : ST_ROOT_WAIT;
			default:      state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		root_start = 1'b0;
		unique case (state_q)
			ST_ROOT_GO: root_start = 1'b1;
			default:    root_start = 1'b0;
		endcase
	end

	sed_isqrt #(.RAD_W(RAD_W)) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.rad    (RAD_W'(total_q)),
		.done   (root_done),
		.root   (root)
	);

	assign root_ext = EXT_W'(root);
	assign dist_sat = (root_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : root_ext[19:0];

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[cnt_a_q[IDX_W-1:0]] <= {new_key, cmd.score};
		end
		if (we_b) begin
			mem_b[cnt_b_q[IDX_W-1:0]] <= {new_key, cmd.score};
		end
		rd_a_q <= mem_a[i_q[IDX_W-1:0]];
		rd_b_q <= mem_b[j_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= cmd.kind;
		end
		mag_s1  <= v_abs[15:0];
		prod_s2 <= 32'(mag_s1) * 32'(mag_s1);
		if (pop) begin
			total_q <= '0;
		end else if (prod_v_s2) begin
			total_q <= total_q + SUM_W'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_a_q      <= '0;
			cnt_b_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			mag_v_s1     <= 1'b0;
			prod_v_s2    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= 1'b0;
			out_shared_q <= 1'b0;
			out_neg_q    <= '0;
		end else begin
			state_q   <= state_d;
			mag_v_s1  <= (state_q == ST_COMPARE) && (kind_q == KIND_COMPUTE) && !walk_end;
			prod_v_s2 <= mag_v_s1;
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (we_a) begin
				cnt_a_q <= cnt_a_q + 1'b1;
			end
			if (we_b) begin
				cnt_b_q <= cnt_b_q + 1'b1;
			end
			if (pop) begin
				i_q <= '0;
				j_q <= '0;
				if (cmd.kind == KIND_APPEND_A || cmd.kind == KIND_APPEND_B) begin
					out_valid_q  <= 1'b1;
					out_status_q <= (cmd.kind == KIND_APPEND_A) ? full_a : full_b;
					out_shared_q <= 1'b0;
					out_neg_q    <= '0;
				end
			end
			if (state_q == ST_COMPARE) begin
				if (eq || take_a) begin
					i_q <= i_q + 1'b1;
				end
				if (eq || take_b) begin
					j_q <= j_q + 1'b1;
				end
				if (kind_q == KIND_SHARE && share_end) begin
					out_valid_q  <= 1'b1;
					out_status_q <= 1'b0;
					out_shared_q <= eq;
					out_neg_q    <= '0;
					cnt_a_q      <= '0;
					cnt_b_q      <= '0;
				end
			end
			if (state_q == ST_ROOT_WAIT && root_done) begin
				out_valid_q  <= 1'b1;
				out_status_q <= 1'b0;
				out_shared_q <= 1'b0;
				out_neg_q    <= DIST_W'(0) - {1'b0, dist_sat};
				cnt_a_q      <= '0;
				cnt_b_q      <= '0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign out_status       = out_status_q;
	assign out_shared       = out_shared_q;
	assign out_neg_distance = out_neg_q;

endmodule
